FILE: rtl/ale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types, codes and constants for the array list engine
// no dependencies

package ale_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int TYPE_W       = 3;
    localparam int IDX_W        = 6;
    localparam int WORD_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 7;
    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 48;

    typedef enum logic [TYPE_W-1:0] {
        REQ_READ   = 3'd0,
        REQ_WRITE  = 3'd1,
        REQ_APPEND = 3'd2,
        REQ_INSERT = 3'd3,
        REQ_REMOVE = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_IDX  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        A_IDX    = 3'd0,
        A_LEN    = 3'd1,
        A_CUR    = 3'd2,
        A_CUR_M1 = 3'd3,
        A_CUR_P1 = 3'd4
    } t_addr_sel;

    typedef enum logic {
        W_VALUE = 1'b0,
        W_RDATA = 1'b1
    } t_wdata_sel;

    typedef struct packed {
        logic       req_load;
        logic       set_status;
        t_status    status;
        logic       mem_rd;
        logic       mem_wr;
        t_addr_sel  addr_sel;
        t_wdata_sel wdata_sel;
        logic       data_cap;
        logic       cur_ld_len;
        logic       cur_ld_idx;
        logic       cur_inc;
        logic       cur_dec;
        logic       len_inc;
        logic       len_dec;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic full;
        logic idx_ge_len;
        logic idx_gt_len;
        logic cur_gt_idx;
        logic cur_p1_lt_len;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/ale_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// controller fsm for the array list engine: sequences memory reads, writes and shifts
// depends on ale_pkg

module ale_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    input  wire ale_pkg::t_stat i_stat,
    output ale_pkg::t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_CAP    = 8'b0000_0100,
        S_REM    = 8'b0000_1000,
        S_REM_WR = 8'b0001_0000,
        S_INS    = 8'b0010_0000,
        S_INS_WR = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state              = r_state;
        o_cmd                = '0;
        o_cmd.status         = ale_pkg::ST_OK;
        o_cmd.addr_sel       = ale_pkg::A_IDX;
        o_cmd.wdata_sel      = ale_pkg::W_VALUE;
        o_cmd.req_load       = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_OUT;
                unique case (i_stat.req) inside
                    ale_pkg::REQ_READ, ale_pkg::REQ_REMOVE: begin
                        if (i_stat.idx_ge_len) begin
                            o_cmd.status = ale_pkg::ST_IDX;
                        end else begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_CAP;
                        end
                    end
                    ale_pkg::REQ_WRITE: begin
                        if (i_stat.idx_ge_len) begin
                            o_cmd.status = ale_pkg::ST_IDX;
                        end else begin
                            o_cmd.mem_wr = 1'b1;
                        end
                    end
                    ale_pkg::REQ_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.status = ale_pkg::ST_FULL;
                        end else begin
                            o_cmd.mem_wr   = 1'b1;
                            o_cmd.addr_sel = ale_pkg::A_LEN;
                            o_cmd.len_inc  = 1'b1;
                        end
                    end
                    ale_pkg::REQ_INSERT: begin
                        if (i_stat.idx_gt_len) begin
                            o_cmd.status = ale_pkg::ST_IDX;
                        end else if (i_stat.full) begin
                            o_cmd.status = ale_pkg::ST_FULL;
                        end else begin
                            o_cmd.cur_ld_len = 1'b1;
                            n_state          = S_INS;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_CAP: begin
                o_cmd.data_cap = 1'b1;
                if (i_stat.req == ale_pkg::REQ_REMOVE) begin
                    o_cmd.cur_ld_idx = 1'b1;
                    n_state          = S_REM;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_REM: begin
                if (i_stat.cur_p1_lt_len) begin
                    o_cmd.mem_rd   = 1'b1;
                    o_cmd.addr_sel = ale_pkg::A_CUR_P1;
                    n_state        = S_REM_WR;
                end else begin
                    o_cmd.len_dec = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_REM_WR: begin
                o_cmd.mem_wr    = 1'b1;
                o_cmd.addr_sel  = ale_pkg::A_CUR;
                o_cmd.wdata_sel = ale_pkg::W_RDATA;
                o_cmd.cur_inc   = 1'b1;
                n_state         = S_REM;
            end
            S_INS: begin
                if (i_stat.cur_gt_idx) begin
                    o_cmd.mem_rd   = 1'b1;
                    o_cmd.addr_sel = ale_pkg::A_CUR_M1;
                    n_state        = S_INS_WR;
                end else begin
                    o_cmd.mem_wr  = 1'b1;
                    o_cmd.len_inc = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_INS_WR: begin
                o_cmd.mem_wr    = 1'b1;
                o_cmd.addr_sel  = ale_pkg::A_CUR;
                o_cmd.wdata_sel = ale_pkg::W_RDATA;
                o_cmd.cur_dec   = 1'b1;
                n_state         = S_INS;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_DECODE)
        else $error("accepted transaction not decoded");

    a_rem_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM_WR) |-> $past(r_state == S_REM))
        else $error("remove shift write without preceding read");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !w_out_free) |=> r_state == S_OUT)
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

FILE: rtl/ale_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// datapath for the array list engine: request latch, element memory, length and cursor
// depends on ale_pkg

module ale_dpath #(
    parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [ale_pkg::TYPE_W-1:0]         i_req_type,
    input  wire logic [ale_pkg::IDX_W-1:0]          i_index,
    input  wire logic signed [ale_pkg::WORD_W-1:0]  i_value,
    input  wire ale_pkg::t_cmd                      i_cmd,
    output ale_pkg::t_stat                          o_stat,
    output logic [ale_pkg::STATUS_W-1:0]            o_status,
    output logic signed [ale_pkg::WORD_W-1:0]       o_data,
    output logic [ale_pkg::LEN_W-1:0]               o_length
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int IW = (LW > ale_pkg::IDX_W) ? LW : ale_pkg::IDX_W;
    localparam int OW = (LW > ale_pkg::LEN_W) ? LW : ale_pkg::LEN_W;

    logic [ale_pkg::WORD_W-1:0]   r_mem [CAPACITY];
    ale_pkg::t_req                r_req;
    logic [ale_pkg::IDX_W-1:0]    r_index;
    logic [ale_pkg::WORD_W-1:0]   r_value;
    logic [LW-1:0]                r_len;
    logic [LW-1:0]                r_cur;
    logic [ale_pkg::WORD_W-1:0]   r_rdata;
    ale_pkg::t_status             r_status;
    logic [ale_pkg::WORD_W-1:0]   r_data;
    logic [ale_pkg::STATUS_W-1:0] r_o_status;
    logic [ale_pkg::WORD_W-1:0]   r_o_data;
    logic [ale_pkg::LEN_W-1:0]    r_o_len;

    logic [IW-1:0]                w_idx_ext;
    logic [IW-1:0]                w_len_ext;
    logic [IW-1:0]                w_cur_ext;
    logic [LW-1:0]                w_cur_p1;
    logic [LW-1:0]                w_addr_full;
    logic [AW-1:0]                w_addr;
    logic [ale_pkg::WORD_W-1:0]   w_wdata;
    logic [OW-1:0]                w_len_wide;

    assign w_idx_ext  = IW'(r_index);
    assign w_len_ext  = IW'(r_len);
    assign w_cur_ext  = IW'(r_cur);
    assign w_cur_p1   = r_cur + LW'(1);
    assign w_len_wide = OW'(r_len);

    assign o_stat.req           = r_req;
    assign o_stat.full          = (r_len == LW'(CAPACITY));
    assign o_stat.idx_ge_len    = (w_idx_ext >= w_len_ext);
    assign o_stat.idx_gt_len    = (w_idx_ext > w_len_ext);
    assign o_stat.cur_gt_idx    = (w_cur_ext > w_idx_ext);
    assign o_stat.cur_p1_lt_len = (w_cur_p1 < r_len);

    always_comb begin
        unique case (i_cmd.addr_sel)
            ale_pkg::A_IDX:    w_addr_full = w_idx_ext[LW-1:0];
            ale_pkg::A_LEN:    w_addr_full = r_len;
            ale_pkg::A_CUR:    w_addr_full = r_cur;
            ale_pkg::A_CUR_M1: w_addr_full = r_cur - LW'(1);
            ale_pkg::A_CUR_P1: w_addr_full = w_cur_p1;
            default:           w_addr_full = r_cur;
        endcase
    end

    assign w_addr  = w_addr_full[AW-1:0];
    assign w_wdata = (i_cmd.wdata_sel == ale_pkg::W_RDATA) ? r_rdata : r_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.len_inc) begin
            r_len <= r_len + LW'(1);
        end else if (i_cmd.len_dec) begin
            r_len <= r_len - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req   <= ale_pkg::t_req'(i_req_type);
            r_index <= i_index;
            r_value <= i_value;
        end
        if (i_cmd.cur_ld_len) begin
            r_cur <= r_len;
        end else if (i_cmd.cur_ld_idx) begin
            r_cur <= w_idx_ext[LW-1:0];
        end else if (i_cmd.cur_inc) begin
            r_cur <= w_cur_p1;
        end else if (i_cmd.cur_dec) begin
            r_cur <= r_cur - LW'(1);
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
            r_data   <= '0;
        end else if (i_cmd.data_cap) begin
            r_data <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_data   <= r_data;
            r_o_len    <= w_len_wide[ale_pkg::LEN_W-1:0];
        end
    end

    assign o_status = r_o_status;
    assign o_data   = r_o_data;
    assign o_length = r_o_len;

endmodule

`default_nettype wire

FILE: rtl/array_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// array list engine top over ale_ctrl, ale_dpath and ale_pkg: read/overwrite/append/insert/remove
// after accept each request is decoded; overwrite, append, unused types and errors then load the result
// read captures the element first; insert and remove shift the words between index and length first
// each shifted word takes a read and then a write on the single-port element memory
// one transaction in flight; next accept in the cycle after the result is loaded
// synchronous active-low reset clears length and control; memory contents are not cleared

module array_list_engine_core #(
    parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // req_type[2:0], index[8:3], value[40:9], zero pad
    input  wire logic [ale_pkg::S_DATA_W-1:0]   i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // status[1:0], data[33:2], length[40:34], zero pad
    output logic [ale_pkg::M_DATA_W-1:0]        o_m_tdata
);

    ale_pkg::t_cmd                       w_cmd;
    ale_pkg::t_stat                      w_stat;
    logic [ale_pkg::STATUS_W-1:0]        w_status;
    logic signed [ale_pkg::WORD_W-1:0]   w_data;
    logic [ale_pkg::LEN_W-1:0]           w_length;

    ale_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ale_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_type (i_s_tdata[2:0]),
        .i_index    (i_s_tdata[8:3]),
        .i_value    (i_s_tdata[40:9]),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_status   (w_status),
        .o_data     (w_data),
        .o_length   (w_length)
    );

    assign o_m_tdata = {7'd0, w_length, w_data, w_status};

endmodule

`default_nettype wire

FILE: test/array_list_engine_core_tb.sv
`timescale 1ns / 1ps
// testbench for array_list_engine_core: directed and random list requests over the stream ports
// depends on ale_pkg and array_list_engine_core; results checked against an in-bench list model

module array_list_engine_core_tb;

    localparam int          CAP             = ale_pkg::CAPACITY_DEF;
    localparam int          CYCLE_LIMIT     = 2_000_000;
    localparam int          HOLD_CYCLES     = 300;
    localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;
    localparam logic [31:0] WORD_MIN        = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX        = 32'h7FFF_FFFF;

    typedef struct packed {
        ale_pkg::t_status status;
        logic [31:0]      data;
        logic [6:0]       length;
    } t_list_result;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic [ale_pkg::S_DATA_W-1:0] i_s_tdata  = '0;
    logic                         i_m_tready = 1'b0;
    logic                         o_s_tready;
    logic                         o_m_tvalid;
    logic [ale_pkg::M_DATA_W-1:0] o_m_tdata;

    logic [31:0]    list_words [CAP];
    int             list_len;
    t_list_result   pending_results [$];
    int             error_count   = 0;
    int             cycle_count   = 0;
    int             send_idle_pct = 18;
    int             recv_idle_pct = 73;
    bit             grow_mode     = 1'b1;
    bit             stall_go      = 1'b0;
    logic           sink_hold     = 1'b0;

    array_list_engine_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_list_result apply_list_request(logic [2:0] kind, logic [5:0] pos,
                                                        logic [31:0] word);
        t_list_result r;
        int j;
        r.status = ale_pkg::ST_OK;
        r.data   = '0;
        case (kind)
            ale_pkg::REQ_READ: begin
                if (pos >= list_len) r.status = ale_pkg::ST_IDX;
                else r.data = list_words[pos];
            end
            ale_pkg::REQ_WRITE: begin
                if (pos >= list_len) r.status = ale_pkg::ST_IDX;
                else list_words[pos] = word;
            end
            ale_pkg::REQ_APPEND: begin
                if (list_len >= CAP) begin
                    r.status = ale_pkg::ST_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            ale_pkg::REQ_INSERT: begin
                if (pos > list_len) begin
                    r.status = ale_pkg::ST_IDX;
                end else if (list_len >= CAP) begin
                    r.status = ale_pkg::ST_FULL;
                end else begin
                    for (j = list_len; j > pos; j--) list_words[j] = list_words[j-1];
                    list_words[pos] = word;
                    list_len++;
                end
            end
            ale_pkg::REQ_REMOVE: begin
                if (pos >= list_len) begin
                    r.status = ale_pkg::ST_IDX;
                end else begin
                    r.data = list_words[pos];
                    for (j = pos; j + 1 < list_len; j++) list_words[j] = list_words[j+1];
                    list_len--;
                end
            end
            default: ;
        endcase
        r.length = 7'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic send_request(logic [2:0] kind, logic [5:0] pos, logic [31:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'b0, word, pos, kind};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(apply_list_request(kind, pos, word));
    endtask

    // result checker and sink-side ready
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", o_m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[1:0] !== want.status)
                    report_mismatch("status", 32'(o_m_tdata[1:0]), 32'(want.status));
                if (o_m_tdata[33:2] !== want.data)
                    report_mismatch("data", o_m_tdata[33:2], want.data);
                if (o_m_tdata[40:34] !== want.length)
                    report_mismatch("length", 32'(o_m_tdata[40:34]), 32'(want.length));
            end
        end
        i_m_tready <= !sink_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // long sink hold-off
    initial begin
        forever begin
            wait (stall_go);
            @(posedge i_clk);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            sink_hold <= 1'b0;
            stall_go = 1'b0;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(39))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_request(output bit spare);
        logic [2:0]  kind;
        logic [5:0]  pos;
        int unsigned roll;
        int          top;
        if (list_len == 0) grow_mode = 1'b1;
        else if (list_len == CAP) grow_mode = 1'b0;
        else if ($urandom_range(99) < 2) grow_mode = !grow_mode;
        roll = $urandom_range(99);
        if (roll < 3) begin
            kind = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        end else if (roll < 20) begin
            kind = ale_pkg::REQ_READ;
        end else if (roll < 32) begin
            kind = ale_pkg::REQ_WRITE;
        end else if (grow_mode) begin
            kind = (roll < 62) ? ale_pkg::REQ_APPEND :
                   (roll < 88) ? ale_pkg::REQ_INSERT : ale_pkg::REQ_REMOVE;
        end else begin
            kind = (roll < 76) ? ale_pkg::REQ_REMOVE :
                   (roll < 88) ? ale_pkg::REQ_APPEND : ale_pkg::REQ_INSERT;
        end
        top = (kind == ale_pkg::REQ_INSERT) ? list_len : list_len - 1;
        if (top > CAP - 1) top = CAP - 1;
        if (top < 0 || $urandom_range(99) < 15) pos = 6'($urandom_range(CAP - 1));
        else pos = 6'($urandom_range(top));
        spare = (kind >= REQ_SPARE_FIRST);
        send_request(kind, pos, pick_word());
    endtask

    task automatic test_empty_list();
        send_request(ale_pkg::REQ_READ, 6'd0, '0);
        send_request(ale_pkg::REQ_REMOVE, 6'd0, '0);
        send_request(ale_pkg::REQ_WRITE, 6'd0, WORD_MAX);
        send_request(ale_pkg::REQ_INSERT, 6'd1, WORD_MIN);
        send_request(ale_pkg::REQ_READ, 6'd63, '1);
    endtask

    task automatic test_basic_ops();
        send_request(ale_pkg::REQ_INSERT, 6'd0, WORD_MIN);
        send_request(ale_pkg::REQ_APPEND, 6'd0, WORD_MAX);
        send_request(ale_pkg::REQ_APPEND, 6'd63, '1);
        send_request(ale_pkg::REQ_INSERT, 6'd1, '0);
        send_request(ale_pkg::REQ_INSERT, 6'd0, 32'h0000_0001);
        send_request(ale_pkg::REQ_READ, 6'd0, '0);
        send_request(ale_pkg::REQ_READ, 6'd4, '0);
        send_request(ale_pkg::REQ_WRITE, 6'd2, 32'h5555_5555);
        send_request(ale_pkg::REQ_WRITE, 6'd5, 32'hAAAA_AAAA);
        send_request(ale_pkg::REQ_READ, 6'd2, '0);
        send_request(ale_pkg::REQ_INSERT, 6'd6, 32'h1234_5678);
        send_request(ale_pkg::REQ_REMOVE, 6'd2, '0);
        send_request(ale_pkg::REQ_REMOVE, 6'd3, '0);
        send_request(ale_pkg::REQ_REMOVE, 6'd0, '0);
        send_request(ale_pkg::REQ_READ, 6'd63, '0);
    endtask

    task automatic test_unused_types();
        for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
            send_request(3'(k), 6'd63, '1);
    endtask

    task automatic test_full_list();
        while (list_len < CAP) send_request(ale_pkg::REQ_APPEND, 6'($urandom), pick_word());
        send_request(ale_pkg::REQ_APPEND, 6'd0, WORD_MAX);
        send_request(ale_pkg::REQ_INSERT, 6'd0, WORD_MIN);
        send_request(ale_pkg::REQ_INSERT, 6'd63, '1);
        send_request(ale_pkg::REQ_READ, 6'd63, '0);
        send_request(ale_pkg::REQ_WRITE, 6'd63, 32'hDEAD_BEEF);
        send_request(ale_pkg::REQ_REMOVE, 6'd0, '0);
        send_request(ale_pkg::REQ_INSERT, 6'd0, 32'h0F0F_0F0F);
        send_request(ale_pkg::REQ_REMOVE, 6'd63, '0);
    endtask

    task automatic test_sink_stall();
        bit spare;
        stall_go = 1'b1;
        repeat (16) send_random_request(spare);
    endtask

    task automatic test_random_traffic(int count, int src_pct, int snk_pct);
        int  done;
        bit  spare;
        send_idle_pct = src_pct;
        recv_idle_pct = snk_pct;
        done = 0;
        while (done < count) begin
            send_random_request(spare);
            if (!spare) done++;
        end
    endtask

    initial begin
        list_len = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_basic_ops();
        test_unused_types();
        test_full_list();
        test_sink_stall();
        test_random_traffic(470, 18, 73);
        test_random_traffic(470, 73, 18);
        test_random_traffic(460, 0, 0);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * CAP + 16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
